/* hw/rtl/msebf_pkg.sv */
package msebf_pkg;

  // Element width and the widths that follow from it.
  localparam int VALUE_WIDTH  = 16;
  localparam int DIFF_W       = VALUE_WIDTH + 1;
  localparam int PROD_W       = 2 * VALUE_WIDTH;

  // Accumulator and count widths.
  localparam int MAX_ELEMENTS = 65536;
  localparam int SUM_W        = 48;
  localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
  localparam int THR_W        = 16;
  localparam int MEAN_W       = 32;

  // Step counter covers the longest iteration, which is the division.
  localparam int STEP_W       = $clog2(SUM_W);

  localparam logic [THR_W-1:0] THRESH_RESET = THR_W'(1434);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIFF,
    ST_ABS,
    ST_CMP,
    ST_MUL,
    ST_ACC,
    ST_DIV,
    ST_DONE
  } msebf_state_t;

  typedef struct packed {
    logic [MEAN_W-1:0] mean_sq_error;
    logic [CNT_W-1:0]  fail_count;
    logic              count_overflow;
  } msebf_result_t;

  typedef struct packed {
    logic             idle;
    logic [CNT_W-1:0] count;
  } msebf_status_t;

endpackage

/* hw/rtl/msebf_addsub.sv */
module msebf_addsub (
  input  logic [msebf_pkg::SUM_W-1:0] a,
  input  logic [msebf_pkg::SUM_W-1:0] b,
  input  logic                        sub,
  output logic [msebf_pkg::SUM_W-1:0] sum,
  output logic                        carry
);
  import msebf_pkg::*;

  logic [SUM_W:0] full;

  // For a subtraction the carry out is set when a >= b as unsigned values.
  assign full  = {1'b0, a} + {1'b0, (sub ? ~b : b)} + (SUM_W+1)'(sub);
  assign sum   = full[SUM_W-1:0];
  assign carry = full[SUM_W];

endmodule

/* hw/rtl/msebf_core.sv */
module msebf_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [msebf_pkg::THR_W-1:0]     cfg_data,
  input  logic                            start,
  input  logic [msebf_pkg::VALUE_WIDTH-1:0] expected_value,
  input  logic [msebf_pkg::VALUE_WIDTH-1:0] produced_value,
  input  logic                            last_element,
  output msebf_pkg::msebf_status_t        status,
  output logic                            res_valid,
  input  logic                            res_ready,
  output msebf_pkg::msebf_result_t        result
);
  import msebf_pkg::*;

  msebf_state_t state, state_next;

  logic [THR_W-1:0]       threshold;
  logic [VALUE_WIDTH-1:0] e_val;
  logic [VALUE_WIDTH-1:0] p_val;
  logic                   last_q;
  logic [DIFF_W-1:0]      diff;
  logic [VALUE_WIDTH-1:0] mag;
  logic                   fail_q;
  logic [VALUE_WIDTH-1:0] hi;
  logic [VALUE_WIDTH-1:0] lo;
  logic [SUM_W-1:0]       error_sum;
  logic [CNT_W-1:0]       element_count;
  logic [CNT_W-1:0]       fail_tally;
  logic                   overflow_seen;
  logic [CNT_W-1:0]       rem;
  logic [SUM_W-1:0]       quo;
  logic [STEP_W-1:0]      step;

  logic [SUM_W-1:0]       add_a;
  logic [SUM_W-1:0]       add_b;
  logic                   add_sub;
  logic [SUM_W-1:0]       add_sum;
  logic                   add_carry;
  logic [VALUE_WIDTH:0]   mul_s;
  logic [CNT_W:0]         trial;
  logic                   count_full;

  assign count_full = (element_count >= CNT_W'(MAX_ELEMENTS));
  assign mul_s      = add_sum[VALUE_WIDTH:0];
  assign trial      = {rem, quo[SUM_W-1]};

  // The one adder in the block; the state picks its operands.
  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_sub = 1'b0;
    case (state)
      ST_DIFF: begin
        add_a   = {{(SUM_W-VALUE_WIDTH){e_val[VALUE_WIDTH-1]}}, e_val};
        add_b   = {{(SUM_W-VALUE_WIDTH){p_val[VALUE_WIDTH-1]}}, p_val};
        add_sub = 1'b1;
      end
      ST_ABS: begin
        add_b   = {{(SUM_W-DIFF_W){diff[DIFF_W-1]}}, diff};
        add_sub = 1'b1;
      end
      ST_CMP: begin
        add_a   = {{(SUM_W-VALUE_WIDTH){1'b0}}, mag};
        add_b   = {{(SUM_W-THR_W){1'b0}}, threshold};
        add_sub = 1'b1;
      end
      ST_MUL: begin
        add_a   = {{(SUM_W-VALUE_WIDTH){1'b0}}, hi};
        add_b   = lo[0] ? {{(SUM_W-VALUE_WIDTH){1'b0}}, mag} : '0;
      end
      ST_ACC: begin
        add_a   = error_sum;
        add_b   = {{(SUM_W-PROD_W){1'b0}}, hi, lo};
      end
      ST_DIV: begin
        add_a   = {{(SUM_W-CNT_W-1){1'b0}}, trial};
        add_b   = {{(SUM_W-CNT_W){1'b0}}, element_count};
        add_sub = 1'b1;
      end
      default: begin
        add_sub = 1'b0;
      end
    endcase
  end

  msebf_addsub u_addsub (
    .a     (add_a),
    .b     (add_b),
    .sub   (add_sub),
    .sum   (add_sum),
    .carry (add_carry)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    res_valid  = 1'b0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          if (!count_full) begin
            state_next = ST_DIFF;
          end else if (last_element) begin
            state_next = ST_DIV;
          end
        end
      end
      ST_DIFF: state_next = ST_ABS;
      ST_ABS:  state_next = ST_CMP;
      ST_CMP:  state_next = ST_MUL;
      ST_MUL: begin
        if (step == '0) begin
          state_next = ST_ACC;
        end
      end
      ST_ACC:  state_next = last_q ? ST_DIV : ST_IDLE;
      ST_DIV: begin
        if (step == '0) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Threshold register.
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESH_RESET;
    end else if (cfg_write) begin
      threshold <= cfg_data;
    end
  end

  // Accumulators.
  always_ff @(posedge clk) begin
    if (rst) begin
      error_sum     <= '0;
      element_count <= '0;
      fail_tally    <= '0;
      overflow_seen <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (start && count_full) begin
            overflow_seen <= 1'b1;
          end
        end
        ST_ACC: begin
          error_sum     <= add_sum;
          element_count <= element_count + CNT_W'(1);
          fail_tally    <= fail_tally + CNT_W'(fail_q);
        end
        ST_DONE: begin
          if (res_ready) begin
            error_sum     <= '0;
            element_count <= '0;
            fail_tally    <= '0;
            overflow_seen <= 1'b0;
          end
        end
        default: begin
          error_sum <= error_sum;
        end
      endcase
    end
  end

  // Working registers of the shared unit.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (start) begin
          e_val  <= expected_value;
          p_val  <= produced_value;
          last_q <= last_element;
          rem    <= '0;
          quo    <= error_sum;
          step   <= STEP_W'(SUM_W - 1);
        end
      end
      ST_DIFF: diff <= add_sum[DIFF_W-1:0];
      ST_ABS:  mag  <= diff[DIFF_W-1] ? add_sum[VALUE_WIDTH-1:0] : diff[VALUE_WIDTH-1:0];
      ST_CMP: begin
        fail_q <= add_carry;
        hi     <= '0;
        lo     <= mag;
        step   <= STEP_W'(VALUE_WIDTH - 1);
      end
      ST_MUL: begin
        hi   <= mul_s[VALUE_WIDTH:1];
        lo   <= {mul_s[0], lo[VALUE_WIDTH-1:1]};
        step <= step - STEP_W'(1);
      end
      ST_ACC: begin
        rem  <= '0;
        quo  <= add_sum;
        step <= STEP_W'(SUM_W - 1);
      end
      ST_DIV: begin
        rem  <= add_carry ? add_sum[CNT_W-1:0] : trial[CNT_W-1:0];
        quo  <= {quo[SUM_W-2:0], add_carry};
        step <= step - STEP_W'(1);
      end
      default: begin
        step <= step;
      end
    endcase
  end

  always_comb begin
    if (element_count == '0) begin
      result.mean_sq_error = '0;
    end else if (|quo[SUM_W-1:MEAN_W]) begin
      result.mean_sq_error = '1;
    end else begin
      result.mean_sq_error = quo[MEAN_W-1:0];
    end
    result.fail_count     = fail_tally;
    result.count_overflow = overflow_seen;
  end

  assign status.idle  = (state == ST_IDLE);
  assign status.count = element_count;

endmodule

/* hw/rtl/mse_and_bit_fail_accumulator.sv */
// Channel   Direction  Handshake            Payload
// in        input      in_valid / in_stall  expected_value, produced_value, last_element
// out       output     out_valid / out_stall mean_sq_error, fail_count, count_overflow
// cfg       input      cfg_write            cfg_data (bit fail threshold)
//
// An element is taken in the idle state, then passes three times through the shared
// adder for difference, magnitude and threshold compare, 16 shift-add steps for
// the square, and an accumulate step. The last element of a set adds 48 restoring
// division steps and a done state that hands the result to the output register.
// An element that arrives with the count already full is dropped and only flagged.
// Reset is synchronous and clears the accumulators and sets the threshold to 1434.
// A stalled result sits in the output register while the next set accumulates.
module mse_and_bit_fail_accumulator (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [msebf_pkg::THR_W-1:0]       cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [msebf_pkg::VALUE_WIDTH-1:0] expected_value,
  input  logic signed [msebf_pkg::VALUE_WIDTH-1:0] produced_value,
  input  logic                              last_element,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [msebf_pkg::MEAN_W-1:0]      mean_sq_error,
  output logic [msebf_pkg::CNT_W-1:0]       fail_count,
  output logic                              count_overflow
);
  import msebf_pkg::*;

  msebf_status_t core_stat;
  msebf_result_t core_res;
  logic          res_valid;
  logic          res_ready;
  logic          res_fire;
  logic          in_fire;

  // The sequencer takes a new element only while it is idle.
  assign in_stall = !core_stat.idle;
  assign in_fire  = in_valid && !in_stall;

  // The output register can load when it is empty or its transfer completes now.
  assign res_ready = !out_valid || !out_stall;
  assign res_fire  = res_valid && res_ready;

  msebf_core u_core (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data),
    .start          (in_fire),
    .expected_value (expected_value),
    .produced_value (produced_value),
    .last_element   (last_element),
    .status         (core_stat),
    .res_valid      (res_valid),
    .res_ready      (res_ready),
    .result         (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_fire) begin
      mean_sq_error  <= core_res.mean_sq_error;
      fail_count     <= core_res.fail_count;
      count_overflow <= core_res.count_overflow;
    end
  end

  // The element count never runs past its limit.
  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    core_stat.count <= CNT_W'(MAX_ELEMENTS))
    else $error("element count exceeded its limit");

  // A result never reports more fails than elements it covers.
  a_fail_le_count: assert property (@(posedge clk) disable iff (rst)
    res_fire |-> core_res.fail_count <= core_stat.count)
    else $error("fail count above element count");

  // Handing over a result clears the accumulators and frees the input.
  a_clear_after_result: assert property (@(posedge clk) disable iff (rst)
    res_fire |=> core_stat.count == '0 && core_stat.idle)
    else $error("accumulators not cleared after result");

endmodule

/* test/mse_and_bit_fail_accumulator_tb.sv */
module mse_and_bit_fail_accumulator_tb;
  import msebf_pkg::*;

  // Predicts what the accumulator should report at the end of each set.
  // It keeps its own copy of the threshold and of the running totals, and
  // a queue of the set results that are still on their way out of the block.
  class set_error_stats;
    logic [THR_W-1:0] threshold;
    logic [63:0]      sq_sum;
    int unsigned      elem_count;
    int unsigned      fail_tally;
    bit               overflow_seen;
    msebf_result_t    awaited_results[$];
    int unsigned      failures;
    int unsigned      results_checked;
    int unsigned      elements_seen;
    int unsigned      sets_closed;

    function new();
      threshold = THRESH_RESET;
      sq_sum = '0;
      elem_count = 0;
      fail_tally = 0;
      overflow_seen = 1'b0;
      failures = 0;
      results_checked = 0;
      elements_seen = 0;
      sets_closed = 0;
    endfunction

    function void report(string msg);
      failures++;
      if (failures <= 10) begin
        $display("%s", msg);
      end
    endfunction

    function void accumulate_element(logic signed [VALUE_WIDTH-1:0] e_val,
                                     logic signed [VALUE_WIDTH-1:0] p_val,
                                     logic last_val);
      logic signed [DIFF_W-1:0] diff;
      logic [DIFF_W-1:0]        mag;
      logic [63:0]              sq;
      logic [63:0]              mean;
      msebf_result_t            res;
      elements_seen++;
      if (elem_count >= MAX_ELEMENTS) begin
        // A full set drops the element and only remembers that it happened.
        overflow_seen = 1'b1;
      end else begin
        diff = e_val - p_val;
        mag = diff[DIFF_W-1] ? -diff : diff;
        sq = 64'(mag) * 64'(mag);
        // The sum cannot get near the top at this element width, but it
        // saturates rather than wraps all the same.
        if (sq_sum > ~64'd0 - sq) begin
          sq_sum = '1;
        end else begin
          sq_sum = sq_sum + sq;
        end
        if (mag >= threshold) begin
          fail_tally++;
        end
        elem_count++;
      end
      if (last_val) begin
        mean = (elem_count != 0) ? sq_sum / 64'(elem_count) : 64'd0;
        res.mean_sq_error  = (mean > 64'hFFFF_FFFF) ? '1 : mean[MEAN_W-1:0];
        res.fail_count     = (fail_tally > 32'h1FFFF) ? '1 : fail_tally[CNT_W-1:0];
        res.count_overflow = overflow_seen;
        awaited_results.push_back(res);
        sets_closed++;
        sq_sum = '0;
        elem_count = 0;
        fail_tally = 0;
        overflow_seen = 1'b0;
      end
    endfunction

    function void check_result(msebf_result_t got);
      msebf_result_t want;
      if (awaited_results.size() == 0) begin
        report($sformatf("Unexpected result: mse %0d fails %0d overflow %0b",
                         got.mean_sq_error, got.fail_count, got.count_overflow));
        return;
      end
      want = awaited_results.pop_front();
      results_checked++;
      if (got.mean_sq_error !== want.mean_sq_error || got.fail_count !== want.fail_count ||
          got.count_overflow !== want.count_overflow) begin
        report($sformatf({"Mismatch in set %0d: expected mse %0d fails %0d overflow %0b, ",
                          "got mse %0d fails %0d overflow %0b"},
                         results_checked, want.mean_sq_error, want.fail_count,
                         want.count_overflow, got.mean_sq_error, got.fail_count,
                         got.count_overflow));
      end
    endfunction
  endclass

  logic                          clk;
  logic                          rst;
  logic                          cfg_write;
  logic [THR_W-1:0]              cfg_data;
  logic                          in_valid;
  logic                          in_stall;
  logic signed [VALUE_WIDTH-1:0] expected_value;
  logic signed [VALUE_WIDTH-1:0] produced_value;
  logic                          last_element;
  logic                          out_valid;
  logic                          out_stall;
  logic [MEAN_W-1:0]             mean_sq_error;
  logic [CNT_W-1:0]              fail_count;
  logic                          count_overflow;

  set_error_stats stats;

  // Idling mix of the current phase, in percent, and the remaining length
  // of a deliberate output hold-off.
  int unsigned send_gap_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_off_left;

  // Random phases: no idling, sender idle, receiver stalling, both, and so on.
  // The last phase again has no idling at all.
  int unsigned gap_mix[8]     = '{0, 54, 0, 31, 54, 0, 31, 0};
  int unsigned stall_mix[8]   = '{0, 0, 54, 31, 0, 54, 31, 0};
  int unsigned phase_items[8] = '{100, 90, 90, 120, 90, 90, 90, 80};

  mse_and_bit_fail_accumulator dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .expected_value (expected_value),
    .produced_value (produced_value),
    .last_element   (last_element),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .mean_sq_error  (mean_sq_error),
    .fail_count     (fail_count),
    .count_overflow (count_overflow)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop. The slowest correct run is dominated by the set that runs the
  // element count past its limit, and this timeout leaves several times that
  // much room.
  initial begin
    #12_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // Mostly full range values, with the two extremes showing up often enough
  // that the largest differences of both signs come around regularly.
  function automatic logic signed [VALUE_WIDTH-1:0] pick_value();
    if ($urandom_range(7) == 0) begin
      return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
    end
    return VALUE_WIDTH'($urandom);
  endfunction

  // Offers one element and holds it until the block takes the transfer. The
  // task is entered and left at a falling edge, so the payload always changes
  // at a falling edge, away from the rising edge that samples it. Valid is left high on
  // return, so a following element goes out without a gap unless the idle
  // draw asks for one.
  task automatic send_element(input logic signed [VALUE_WIDTH-1:0] e_val,
                              input logic signed [VALUE_WIDTH-1:0] p_val,
                              input logic last_val);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid = 1'b0;
      repeat ($urandom_range(6, 1)) @(negedge clk);
    end
    in_valid = 1'b1;
    expected_value = e_val;
    produced_value = p_val;
    last_element = last_val;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    stats.accumulate_element(e_val, p_val, last_val);
    @(negedge clk);
  endtask

  // Sends random sets of one to max_len elements until about n_items have
  // gone out. Each set is closed by its own last element, so a phase always
  // ends with every set complete. Half of the pairs sit close together,
  // which puts the absolute error right around the usual thresholds.
  task automatic stream_sets(input int unsigned n_items, input int unsigned max_len);
    int unsigned                   sent;
    int unsigned                   set_len;
    logic signed [VALUE_WIDTH-1:0] e_val;
    logic signed [VALUE_WIDTH-1:0] p_val;
    sent = 0;
    while (sent < n_items) begin
      set_len = $urandom_range(max_len, 1);
      for (int unsigned k = 1; k <= set_len; k++) begin
        e_val = pick_value();
        case ($urandom_range(3))
          0: p_val = pick_value();
          1: p_val = e_val;
          default: p_val = e_val - VALUE_WIDTH'($urandom_range(4096)) + VALUE_WIDTH'(2048);
        endcase
        send_element(e_val, p_val, k == set_len);
        sent++;
      end
    end
  endtask

  // Drops valid and waits until every set result has come out.
  task automatic wait_for_results();
    in_valid = 1'b0;
    while (stats.awaited_results.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Writes the threshold while the block is quiet. The pause covers the
  // longest stretch the block may still be busy after its last result: the
  // processing of a closing element, with its division.
  task automatic load_threshold(input logic [THR_W-1:0] value);
    repeat (80) @(negedge clk);
    cfg_data = value;
    cfg_write = 1'b1;
    @(negedge clk);
    cfg_write = 1'b0;
    stats.threshold = value;
  endtask

  // Receiver side. The stall line changes only at the falling edge. A pending
  // hold-off keeps it high for a long run of cycles, which lets one result sit
  // in the output register while the next set closes behind it.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_off_left > 0) begin
        out_stall = 1'b1;
        hold_off_left--;
      end else begin
        out_stall = ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // Every transfer on the result channel is checked at the edge that takes it.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      stats.check_result({mean_sq_error, fail_count, count_overflow});
    end
  end

  initial begin
    logic [THR_W-1:0] thr;
    int unsigned      waited;
    stats = new();
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    expected_value = '0;
    produced_value = '0;
    last_element = 1'b0;
    out_stall = 1'b0;
    send_gap_pct = 0;
    recv_stall_pct = 0;
    hold_off_left = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed sets under the reset threshold of 1434.
    // Largest difference in both directions, each as a set of one element.
    send_element(16'sh7FFF, 16'sh8000, 1'b1);
    send_element(16'sh8000, 16'sh7FFF, 1'b1);
    // No error at all.
    send_element(16'sh0000, 16'sh0000, 1'b1);
    // Errors exactly at, just below, and at the threshold with negative sign.
    send_element(16'sd1434, 16'sh0000, 1'b0);
    send_element(16'sh0000, 16'sd1433, 1'b0);
    send_element(-16'sd1434, 16'sh0000, 1'b1);
    // Matching extremes give no error over two elements.
    send_element(16'sh8000, 16'sh8000, 1'b0);
    send_element(16'sh7FFF, 16'sh7FFF, 1'b1);
    wait_for_results();

    // With a zero threshold even a perfect match counts as failed.
    load_threshold('0);
    send_element(16'sd5, 16'sd5, 1'b0);
    send_element(16'sd3, -16'sd3, 1'b1);
    wait_for_results();

    // With the largest threshold only the very largest error fails.
    load_threshold('1);
    send_element(16'sh7FFF, 16'sh8000, 1'b0);
    send_element(16'sh8000, 16'sh7FFF, 1'b0);
    send_element(16'sh7FFE, 16'sh8000, 1'b1);
    wait_for_results();

    // Random phases, each under its own threshold and idling mix.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        1: thr = '0;
        2: thr = '1;
        4: thr = THR_W'($urandom);
        5: thr = THRESH_RESET;
        default: thr = THR_W'($urandom_range(2048, 1));
      endcase
      load_threshold(thr);
      send_gap_pct = gap_mix[ph];
      recv_stall_pct = stall_mix[ph];
      // The first phase opens with a long output hold-off and short sets, so
      // the block fills up and has to stall its input.
      if (ph == 0) begin
        hold_off_left = 400;
      end
      stream_sets(phase_items[ph], (ph == 0) ? 3 : 12);
      wait_for_results();
    end

    // One set that runs past the element limit. The elements after the limit
    // are dropped, the count is flagged, and the closing element still yields
    // a result. A zero threshold drives the fail count up to the element limit.
    load_threshold('0);
    send_gap_pct = 0;
    recv_stall_pct = 0;
    for (int k = 1; k <= MAX_ELEMENTS + 3; k++) begin
      send_element(pick_value(), pick_value(), k == MAX_ELEMENTS + 3);
    end
    in_valid = 1'b0;

    // Wait for the tail, bounded, then give the block time to show anything
    // extra it might still put out.
    waited = 0;
    while (stats.awaited_results.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (100) @(posedge clk);
    while (stats.awaited_results.size() != 0) begin
      stats.report("A set result never came out of the block");
      void'(stats.awaited_results.pop_front());
    end

    $display("Run covered %0d elements in %0d sets, %0d results checked, %0d failures.",
             stats.elements_seen, stats.sets_closed, stats.results_checked, stats.failures);
    $display("Thresholds 0, 1434, 65535 and random, idling on both sides, and one set past %0d.",
             MAX_ELEMENTS);
    if (stats.failures == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
